/* rtl/core/oas_pkg.sv */
// Shared constants, types and helper functions of the output action scheduler.
`default_nettype none

package oas_pkg;

    // Table geometry
    localparam int CHANNELS    = 256;
    localparam int GROUP_WIDTH = 8;
    localparam int DEPTH       = 2 * CHANNELS;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(GROUP_WIDTH + 1);

    // Fixed field widths
    localparam int CHAN_W  = 8;
    localparam int LANE_W  = 3;
    localparam int GROUP_W = 4;
    localparam int PHASE_W = 3;
    localparam int TIME_W  = 32;
    localparam int MS_W    = 16;
    localparam int STR_W   = 8;

    localparam logic [CHAN_W:0]   CHAN_LIMIT    = (CHAN_W + 1)'(CHANNELS);
    localparam logic [ADDR_W-1:0] TBL_BASE      = ADDR_W'(CHANNELS);
    localparam logic [MS_W-1:0]   PULSE_CNT_MAX = 16'hffff;
    localparam logic [STR_W-1:0]  STRENGTH_MIN  = 8'd1;
    localparam logic [TIME_W-1:0] TIME_HALF     = 32'h8000_0000;

    // Drive gate per small strength: bit p set when p mod s is zero
    localparam logic [7:0] PWM_GATE_TBL [8] = '{
        8'h01, 8'hff, 8'h55, 8'h49, 8'h11, 8'h21, 8'h41, 8'h81
    };

    typedef enum logic [1:0] {
        CMD_SET     = 2'd0,
        CMD_DISABLE = 2'd1,
        CMD_SCAN    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_CONT    = 2'd1,
        MODE_ONESHOT = 2'd2,
        MODE_PULSE   = 2'd3
    } chan_mode_t;

    typedef struct packed {
        chan_mode_t          mode;
        logic [STR_W-1:0]    strength;
        logic                notify;
        logic [TIME_W-1:0]   deadline;
        logic [MS_W-1:0]     on_time;
        logic [MS_W-1:0]     low_time;
        logic                high_half;
        logic [MS_W-1:0]     period_limit;
        logic [MS_W-1:0]     pulse_count;
    } chan_rec_t;

    localparam int REC_W = $bits(chan_rec_t);

    typedef struct packed {
        logic drive;
        logic ended;
    } chan_flags_t;

    // Phase is below eight, so any strength of eight or more divides only phase zero
    function automatic logic pwm_gate(input logic [PHASE_W-1:0] phase,
                                      input logic [STR_W-1:0] strength);
        logic [7:0] row;
        row = PWM_GATE_TBL[strength[2:0]];
        if (strength[STR_W-1:3] != '0)
            return (phase == '0);
        return row[phase];
    endfunction

    function automatic logic chan_live(input logic [CHAN_W-1:0] chan);
        return ({1'b0, chan} < CHAN_LIMIT);
    endfunction

    function automatic logic [ADDR_W-1:0] chan_addr(input logic tbl,
                                                    input logic [CHAN_W-1:0] chan);
        return (tbl ? TBL_BASE : '0) + ADDR_W'(chan);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/oas_in_if.sv */
// Request channel of the output action scheduler: valid, ready and one command item.
`default_nettype none

interface oas_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic        table_select;
    logic [7:0]  channel;
    logic [1:0]  mode;
    logic [7:0]  strength;
    logic [15:0] on_time_ms;
    logic [15:0] off_time_ms;
    logic [15:0] pulse_limit;
    logic        notify;
    logic [3:0]  group;
    logic [2:0]  phase;
    logic [31:0] now_ms;

    modport source (
        output valid, cmd, table_select, channel, mode, strength, on_time_ms,
               off_time_ms, pulse_limit, notify, group, phase, now_ms,
        input  ready
    );

    modport sink (
        input  valid, cmd, table_select, channel, mode, strength, on_time_ms,
               off_time_ms, pulse_limit, notify, group, phase, now_ms,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/oas_out_if.sv */
// Result channel of the output action scheduler: valid, ready and one scan result item.
`default_nettype none

interface oas_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] drive_bits;
    logic [7:0] ended_bits;
    logic [3:0] scanned_group;

    modport source (
        output valid, drive_bits, ended_bits, scanned_group,
        input  ready
    );

    modport sink (
        input  valid, drive_bits, ended_bits, scanned_group,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/oas_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module oas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/oas_chan_update.sv */
// Per-channel scan update: PWM gate, deadline test, pulse toggling and expiry.
`default_nettype none

module oas_chan_update (
    input  oas_pkg::chan_rec_t         rec,
    input  logic [oas_pkg::PHASE_W-1:0] phase,
    input  logic [oas_pkg::TIME_W-1:0]  now_ms,
    output oas_pkg::chan_rec_t         rec_next,
    output oas_pkg::chan_flags_t       flags
);

    import oas_pkg::*;

    logic [TIME_W-1:0] elapsed;
    logic              passed;
    logic [MS_W-1:0]   cnt_inc;
    logic              high_next;
    logic              stop;

    // Deadline passed when now - deadline lies in the forward half of the clock
    assign elapsed   = now_ms - rec.deadline;
    assign passed    = (elapsed != '0) && (elapsed < TIME_HALF);
    assign cnt_inc   = (!rec.high_half && rec.pulse_count != PULSE_CNT_MAX) ?
                       rec.pulse_count + MS_W'(1) : rec.pulse_count;
    assign high_next = !rec.high_half;
    assign stop      = (rec.period_limit != '0) && (cnt_inc >= rec.period_limit);

    always_comb
    begin
        rec_next = rec;
        flags    = '0;
        if (rec.mode != MODE_OFF)
        begin
            flags.drive = (rec.mode != MODE_PULSE || rec.high_half) &&
                          pwm_gate(phase, rec.strength);
            case (rec.mode)
                MODE_ONESHOT:
                begin
                    if (passed)
                    begin
                        rec_next.mode = MODE_OFF;
                        flags.ended   = rec.notify;
                    end
                end
                MODE_PULSE:
                begin
                    if (passed)
                    begin
                        rec_next.pulse_count = cnt_inc;
                        rec_next.high_half   = high_next;
                        rec_next.deadline    = now_ms +
                            TIME_W'(high_next ? rec.on_time : rec.low_time);
                        if (stop)
                        begin
                            rec_next.mode = MODE_OFF;
                            flags.ended   = rec.notify;
                        end
                    end
                end
                default:
                begin
                    // continuous never expires
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/output_action_scheduler.sv */
// Top level of the output action scheduler: command decode, scan sequencer and channel table.
`default_nettype none

// Output action scheduler. Two tables of CHANNELS output channels (lamps at
// table_select 0, solenoids at 1) live in one synchronous RAM of 2*CHANNELS
// records, each holding mode, PWM strength, notify flag, deadline, pulse
// on/off times, pulse limit and pulse count. A set item writes a whole record
// in the cycle it is accepted (strength 0 is stored as 1); a disable item
// writes the record with mode off; channels at or beyond CHANNELS are
// ignored. A scan item walks the GROUP_WIDTH channels at group*16+0..
// through the single RAM read port: one read is issued per cycle, the
// returned record is updated in the next cycle and written back in the one
// after. The scan result (drive byte, ended mask of notifying channels that
// expired, group) sits in an output register, so the next item is taken
// while it waits; a scan only stalls at its end if the previous result has
// still not been taken. After reset the block sweeps the RAM to mark every
// channel off, one record per cycle, and accepts no item until the sweep
// has finished.
module output_action_scheduler (
    input  logic      clk,
    input  logic      rst_n,
    oas_in_if.sink    request,
    oas_out_if.source result
);

    import oas_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Control state
    state_t            state_reg,     state_next;
    logic [ADDR_W-1:0] clr_cnt_reg,   clr_cnt_next;
    logic [CNT_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic              s1_valid_reg,  s1_valid_next;
    logic              s2_valid_reg,  s2_valid_next;
    logic              out_valid_reg, out_valid_next;

    // Payload
    logic [LANE_W-1:0]  s1_lane_reg,    s1_lane_next;
    logic [ADDR_W-1:0]  s1_addr_reg,    s1_addr_next;
    logic [ADDR_W-1:0]  s2_addr_reg,    s2_addr_next;
    chan_rec_t          s2_rec_reg,     s2_rec_next;
    logic [7:0]         drive_acc_reg,  drive_acc_next;
    logic [7:0]         ended_acc_reg,  ended_acc_next;
    logic               tbl_reg,        tbl_next;
    logic [GROUP_W-1:0] grp_reg,        grp_next;
    logic [PHASE_W-1:0] phase_reg,      phase_next;
    logic [TIME_W-1:0]  now_reg,        now_next;
    logic [7:0]         out_drive_reg,  out_drive_next;
    logic [7:0]         out_ended_reg,  out_ended_next;
    logic [GROUP_W-1:0] out_group_reg,  out_group_next;

    // RAM port and datapath
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [REC_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [REC_W-1:0]  mem_rdata;

    logic              accept;
    logic              issuing;
    logic              finish;
    logic [LANE_W-1:0] issue_lane;
    logic [CHAN_W-1:0] scan_chan;
    chan_rec_t         set_rec;
    chan_rec_t         upd_rec;
    chan_flags_t       upd_flags;

    assign request.ready = (state_reg == ST_IDLE);
    assign accept        = request.valid && request.ready;

    assign result.valid         = out_valid_reg;
    assign result.drive_bits    = out_drive_reg;
    assign result.ended_bits    = out_ended_reg;
    assign result.scanned_group = out_group_reg;

    // Scan channel of the lane being issued: group*16 + lane
    assign issue_lane = LANE_W'(issue_cnt_reg);
    assign scan_chan  = {grp_reg, 1'b0, issue_lane};
    assign issuing    = (state_reg == ST_SCAN) && (issue_cnt_reg != CNT_W'(GROUP_WIDTH));
    assign finish     = (state_reg == ST_SCAN) && !issuing && !s1_valid_reg &&
                        !s2_valid_reg && (!out_valid_reg || result.ready);
    assign mem_raddr  = chan_addr(tbl_reg, scan_chan);

    // Record written by a set item; a disable reuses it with mode off.
    // Pulse fields are only read in pulse mode, which always rewrites them.
    always_comb
    begin
        set_rec.mode         = chan_mode_t'(request.mode);
        set_rec.strength     = (request.strength == '0) ? STRENGTH_MIN : request.strength;
        set_rec.notify       = request.notify;
        set_rec.deadline     = request.now_ms + TIME_W'(request.on_time_ms);
        set_rec.on_time      = request.on_time_ms;
        set_rec.low_time     = request.off_time_ms;
        set_rec.high_half    = (chan_mode_t'(request.mode) == MODE_PULSE);
        set_rec.period_limit = request.pulse_limit;
        set_rec.pulse_count  = '0;
        if (cmd_t'(request.cmd) == CMD_DISABLE)
        begin
            set_rec.mode = MODE_OFF;
        end
    end

    // Single write port: clear sweep, set/disable on accept, scan write-back
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = s2_addr_reg;
        mem_wdata = s2_rec_reg;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (s2_valid_reg)
        begin
            mem_we = 1'b1;
        end
        else if (accept && chan_live(request.channel) &&
                 (cmd_t'(request.cmd) == CMD_SET || cmd_t'(request.cmd) == CMD_DISABLE))
        begin
            mem_we    = 1'b1;
            mem_waddr = chan_addr(request.table_select, request.channel);
            mem_wdata = set_rec;
        end
    end

    oas_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    oas_chan_update u_update (
        .rec      (chan_rec_t'(mem_rdata)),
        .phase    (phase_reg),
        .now_ms   (now_reg),
        .rec_next (upd_rec),
        .flags    (upd_flags)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        issue_cnt_next = issue_cnt_reg;
        s1_valid_next  = 1'b0;
        s2_valid_next  = 1'b0;
        out_valid_next = out_valid_reg && !result.ready;

        s1_lane_next   = issue_lane;
        s1_addr_next   = mem_raddr;
        s2_addr_next   = s1_addr_reg;
        s2_rec_next    = upd_rec;
        drive_acc_next = drive_acc_reg;
        ended_acc_next = ended_acc_reg;
        tbl_next       = tbl_reg;
        grp_next       = grp_reg;
        phase_next     = phase_reg;
        now_next       = now_reg;
        out_drive_next = out_drive_reg;
        out_ended_next = out_ended_reg;
        out_group_next = out_group_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                // Latch scan context; set and disable finish on the accept edge
                if (accept && cmd_t'(request.cmd) == CMD_SCAN)
                begin
                    state_next     = ST_SCAN;
                    issue_cnt_next = '0;
                    drive_acc_next = '0;
                    ended_acc_next = '0;
                    tbl_next       = request.table_select;
                    grp_next       = request.group;
                    phase_next     = request.phase;
                    now_next       = request.now_ms;
                end
            end
            ST_SCAN:
            begin
                // Issue one read per cycle; channels past the table stay dark
                if (issuing)
                begin
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    s1_valid_next  = chan_live(scan_chan);
                end
                // Read data is back: update the record and collect its bits
                if (s1_valid_reg)
                begin
                    s2_valid_next                 = 1'b1;
                    drive_acc_next[s1_lane_reg]   = upd_flags.drive;
                    ended_acc_next[s1_lane_reg]   = upd_flags.ended;
                end
                // All write-backs done: hand the result to the output register
                if (finish)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_drive_next = drive_acc_reg;
                    out_ended_next = ended_acc_reg;
                    out_group_next = grp_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            issue_cnt_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            s1_lane_reg   <= '0;
            s1_addr_reg   <= '0;
            s2_addr_reg   <= '0;
            s2_rec_reg    <= '0;
            drive_acc_reg <= '0;
            ended_acc_reg <= '0;
            tbl_reg       <= 1'b0;
            grp_reg       <= '0;
            phase_reg     <= '0;
            now_reg       <= '0;
            out_drive_reg <= '0;
            out_ended_reg <= '0;
            out_group_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            issue_cnt_reg <= issue_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            s1_lane_reg   <= s1_lane_next;
            s1_addr_reg   <= s1_addr_next;
            s2_addr_reg   <= s2_addr_next;
            s2_rec_reg    <= s2_rec_next;
            drive_acc_reg <= drive_acc_next;
            ended_acc_reg <= ended_acc_next;
            tbl_reg       <= tbl_next;
            grp_reg       <= grp_next;
            phase_reg     <= phase_next;
            now_reg       <= now_next;
            out_drive_reg <= out_drive_next;
            out_ended_reg <= out_ended_next;
            out_group_reg <= out_group_next;
        end
    end

    // Scan pipeline is drained whenever the block can take a new item
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !s1_valid_reg && !s2_valid_reg)
        else $error("scan pipeline busy while idle");

    // Write-backs only happen inside a scan, never during the clear sweep
    a_wb_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> state_reg == ST_SCAN)
        else $error("scan write-back outside a scan");

    // Issue counter never runs past the group width
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue_cnt_reg <= CNT_W'(GROUP_WIDTH))
        else $error("issue counter overran group width");

    // A new result only appears at the end of a scan
    a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_SCAN && state_reg == ST_IDLE)
        else $error("result raised outside scan completion");

    // No item is taken before the clear sweep has finished
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |=> !(s1_valid_reg || out_valid_reg) || state_reg != ST_CLEAR)
        else $error("activity during clear sweep");

endmodule

`default_nettype wire
